### rtl/core/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/pclh_pkg.sv
//------------------------------------------------------------------------------
// pclh_pkg
// shared constants, codes, types and helpers of the latency histogram
//------------------------------------------------------------------------------
package pclh_pkg;

	localparam int unsigned CONTEXTS  = 128;
	localparam int unsigned HIST_BINS = 64;

	localparam int unsigned CTX_AW = $clog2(CONTEXTS);
	localparam int unsigned HB_AW  = $clog2(HIST_BINS);

	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned CTX_W     = 7;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned BIDX_W    = 6;
	localparam int unsigned BIN_W     = 7;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [FUNC_W-1:0] F_START    = 3'd0;
	localparam logic [FUNC_W-1:0] F_END      = 3'd1;
	localparam logic [FUNC_W-1:0] F_MARK     = 3'd2;
	localparam logic [FUNC_W-1:0] F_EPTP     = 3'd3;
	localparam logic [FUNC_W-1:0] F_RST_ALL  = 3'd4;
	localparam logic [FUNC_W-1:0] F_HALT_WRD = 3'd5;
	localparam logic [FUNC_W-1:0] F_HALT_ONE = 3'd6;
	localparam logic [FUNC_W-1:0] F_READ     = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_ONLY_NESTED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_EVENT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_L1      = 2'd2;

	localparam logic [31:0]      HALT_EXIT_WORD = 32'h0000_0080;
	localparam logic [BIN_W-1:0] NO_BIN         = 7'd64;

	typedef struct packed {
		logic load;
		logic exec;
		logic commit;
	} pclh_cmd_t;

	function automatic logic [BIN_W-1:0] bit_len_min1(input logic [DATA_W-1:0] v);
		logic [BIN_W-1:0] n;
		n = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (v[i]) begin
				n = BIN_W'(i + 1);
			end
		end
		return (n == '0) ? BIN_W'(1) : n;
	endfunction

endpackage

### rtl/core/pclh_ram.sv
//------------------------------------------------------------------------------
// pclh_ram
// generic simple dual-port ram, one write and one registered read
//------------------------------------------------------------------------------
module pclh_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/pclh_ctrl.sv
//------------------------------------------------------------------------------
// pclh_ctrl
// sequencer: accept, context lookup, histogram commit, output beat hold
//------------------------------------------------------------------------------
module pclh_ctrl import pclh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output pclh_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready   = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.exec   = (state_q == S_RD);
	assign cmd.commit = (state_q == S_UPD) && out_free;
	assign out_valid  = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				state_nx = S_UPD;
			end
			S_UPD: begin
				if (cmd.commit) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/pclh_dp.sv
//------------------------------------------------------------------------------
// pclh_dp
// datapath: context stores, gate logic, totals, histogram and output beat
//------------------------------------------------------------------------------
module pclh_dp import pclh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pclh_cmd_t            cmd,
	input  logic [FUNC_W-1:0]    func,
	input  logic [CTX_W-1:0]     context_index,
	input  logic                 nested,
	input  logic                 halted,
	input  logic [DATA_W-1:0]    timestamp,
	input  logic [DATA_W-1:0]    value,
	input  logic [BIDX_W-1:0]    bin_index,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	output logic                 recorded,
	output logic [DATA_W-1:0]    latency,
	output logic [BIN_W-1:0]     bin_used,
	output logic [DATA_W-1:0]    record_count,
	output logic [DATA_W-1:0]    latency_sum,
	output logic [DATA_W-1:0]    bin_count
);

	// config
	logic only_nested_q;
	logic req_event_q;
	logic req_l1_q;

	// captured item
	logic [FUNC_W-1:0] func_q;
	logic [CTX_W-1:0]  ctx_q;
	logic              nested_q;
	logic              halted_q;
	logic [DATA_W-1:0] ts_q;
	logic [DATA_W-1:0] value_q;
	logic [BIDX_W-1:0] bidx_q;

	// per-context and per-bin valid bits
	logic [CONTEXTS-1:0]  act_vld_q;
	logic [CONTEXTS-1:0]  ept_vld_q;
	logic [HIST_BINS-1:0] hist_vld_q;

	// rams
	logic [DATA_W:0]   act_rd;
	logic [DATA_W:0]   act_wd;
	logic              act_we;
	logic [DATA_W:0]   ept_rd;
	logic [DATA_W:0]   ept_wd;
	logic              ept_we;
	logic [CTX_AW-1:0] ctx_addr;
	logic [DATA_W-1:0] hist_rd;
	logic [HB_AW-1:0]  hist_raddr;

	// lookup stage
	logic              ctx_ok;
	logic              gated;
	logic [DATA_W-1:0] start_v;
	logic              evt_v;
	logic              l1_v;
	logic [DATA_W-1:0] ept_v;
	logic [DATA_W-1:0] lat_c;
	logic [BIN_W-1:0]  bin_c;
	logic              rec_c;
	logic              clr_all;
	logic              clr_one;

	// commit stage
	logic              rec_q;
	logic              bump_q;
	logic              rd_bin_q;
	logic [DATA_W-1:0] lat_q;
	logic [BIN_W-1:0]  used_q;
	logic [HB_AW-1:0]  hist_addr_q;
	logic [DATA_W-1:0] hist_cur;
	logic [DATA_W-1:0] count_q;
	logic [DATA_W-1:0] sum_q;

	// output beat
	logic              recorded_q;
	logic [DATA_W-1:0] latency_q;
	logic [BIN_W-1:0]  bin_used_q;
	logic [DATA_W-1:0] bin_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			only_nested_q <= 1'b1;
			req_event_q   <= 1'b1;
			req_l1_q      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ONLY_NESTED: only_nested_q <= cfg_data;
				CFG_REQ_EVENT:   req_event_q   <= cfg_data;
				CFG_REQ_L1:      req_l1_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			ctx_q    <= context_index;
			nested_q <= nested;
			halted_q <= halted;
			ts_q     <= timestamp;
			value_q  <= value;
			bidx_q   <= bin_index;
		end
	end

	assign ctx_addr = CTX_AW'(ctx_q);

	pclh_ram #(.WIDTH(DATA_W + 1), .DEPTH(CONTEXTS)) u_act_ram (
		.clk     (clk),
		.wr_en   (act_we),
		.wr_addr (ctx_addr),
		.wr_data (act_wd),
		.rd_en   (cmd.load),
		.rd_addr (CTX_AW'(context_index)),
		.rd_data (act_rd)
	);

	pclh_ram #(.WIDTH(DATA_W + 1), .DEPTH(CONTEXTS)) u_ept_ram (
		.clk     (clk),
		.wr_en   (ept_we),
		.wr_addr (ctx_addr),
		.wr_data (ept_wd),
		.rd_en   (cmd.load),
		.rd_addr (CTX_AW'(context_index)),
		.rd_data (ept_rd)
	);

	assign ctx_ok  = (32'(ctx_q) < 32'(CONTEXTS));
	assign gated   = only_nested_q && !nested_q;
	assign start_v = act_vld_q[ctx_addr] ? act_rd[DATA_W-1:0] : '0;
	assign evt_v   = act_vld_q[ctx_addr] && act_rd[DATA_W];
	assign ept_v   = ept_vld_q[ctx_addr] ? ept_rd[DATA_W-1:0] : '0;
	assign l1_v    = ept_vld_q[ctx_addr] && ept_rd[DATA_W];
	assign lat_c   = ts_q - start_v;
	assign bin_c   = bit_len_min1(lat_c);

	always_comb begin
		act_we  = 1'b0;
		act_wd  = {evt_v, start_v};
		ept_we  = 1'b0;
		ept_wd  = {l1_v, ept_v};
		rec_c   = 1'b0;
		clr_all = 1'b0;
		clr_one = 1'b0;
		case (func_q)
			F_START: begin
				if (ctx_ok && !gated) begin
					act_we = 1'b1;
					act_wd = {evt_v && !req_event_q, ts_q};
				end
			end
			F_END: begin
				if (ctx_ok) begin
					if (req_l1_q && only_nested_q && !nested_q) begin
						if (start_v != '0) begin
							ept_we = 1'b1;
							ept_wd = {1'b1, ept_v};
						end
					end else if (!gated && !(req_l1_q && !l1_v) &&
							!(req_event_q && !evt_v) && (start_v != '0)) begin
						rec_c  = 1'b1;
						act_we = 1'b1;
						act_wd = {evt_v && !req_event_q, {DATA_W{1'b0}}};
						ept_we = 1'b1;
						ept_wd = {l1_v && !req_l1_q, ept_v};
					end
				end
			end
			F_MARK: begin
				if (ctx_ok && !gated) begin
					act_we = 1'b1;
					act_wd = {1'b1, start_v};
				end
			end
			F_EPTP: begin
				if (ctx_ok && (ept_v != value_q)) begin
					act_we = 1'b1;
					act_wd = {1'b1, start_v};
					ept_we = 1'b1;
					ept_wd = {l1_v, value_q};
				end
			end
			F_RST_ALL: begin
				clr_all = 1'b1;
			end
			F_HALT_WRD: begin
				clr_all = (value_q[31:0] == HALT_EXIT_WORD);
			end
			F_HALT_ONE: begin
				clr_one = ctx_ok && halted_q;
			end
			F_READ: begin
			end
			default: begin
			end
		endcase
		act_we = act_we && cmd.exec;
		ept_we = ept_we && cmd.exec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_vld_q <= '0;
			ept_vld_q <= '0;
		end else if (cmd.exec) begin
			if (clr_all) begin
				act_vld_q <= '0;
			end else if (clr_one) begin
				act_vld_q[ctx_addr] <= 1'b0;
			end else if (act_we) begin
				act_vld_q[ctx_addr] <= 1'b1;
			end
			if (ept_we) begin
				ept_vld_q[ctx_addr] <= 1'b1;
			end
		end
	end

	// histogram lookup for a record or a bin read
	assign hist_raddr = (func_q == F_READ) ? HB_AW'(bidx_q) : HB_AW'(bin_c);

	pclh_ram #(.WIDTH(DATA_W), .DEPTH(HIST_BINS)) u_hist_ram (
		.clk     (clk),
		.wr_en   (cmd.commit && bump_q),
		.wr_addr (hist_addr_q),
		.wr_data (hist_cur + DATA_W'(1)),
		.rd_en   (cmd.exec),
		.rd_addr (hist_raddr),
		.rd_data (hist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q    <= 1'b0;
			bump_q   <= 1'b0;
			rd_bin_q <= 1'b0;
		end else if (cmd.exec) begin
			rec_q    <= rec_c;
			bump_q   <= rec_c && (32'(bin_c) < 32'(HIST_BINS));
			rd_bin_q <= (func_q == F_READ) && (32'(bidx_q) < 32'(HIST_BINS));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			lat_q       <= lat_c;
			used_q      <= bin_c;
			hist_addr_q <= hist_raddr;
		end
	end

	assign hist_cur = hist_vld_q[hist_addr_q] ? hist_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			count_q    <= '0;
			sum_q      <= '0;
		end else if (cmd.commit) begin
			if (bump_q) begin
				hist_vld_q[hist_addr_q] <= 1'b1;
			end
			if (rec_q) begin
				count_q <= count_q + DATA_W'(1);
				sum_q   <= sum_q + lat_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			recorded_q  <= rec_q;
			latency_q   <= rec_q ? lat_q : '0;
			bin_used_q  <= bump_q ? used_q : NO_BIN;
			bin_count_q <= rd_bin_q ? hist_cur : '0;
		end
	end

	assign recorded     = recorded_q;
	assign latency      = latency_q;
	assign bin_used     = bin_used_q;
	assign record_count = count_q;
	assign latency_sum  = sum_q;
	assign bin_count    = bin_count_q;

endmodule

### rtl/core/per_context_latency_histogram_top.sv
//------------------------------------------------------------------------------
// per_context_latency_histogram_top
// per-context latency tracking with log2 latency histogram
//------------------------------------------------------------------------------
// flow: accept in idle, lookup and context write in the lookup state, then
// histogram commit registering the result beat; one item in flight at a time
// a waiting result beat holds the histogram commit until it is taken
// async reset sets config to its defaults and clears context stores, totals
// and bins at once; no sweep
module per_context_latency_histogram_top import pclh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FUNC_W-1:0]    func,
	input  logic [CTX_W-1:0]     context_index,
	input  logic                 nested,
	input  logic                 halted,
	input  logic [DATA_W-1:0]    timestamp,
	input  logic [DATA_W-1:0]    value,
	input  logic [BIDX_W-1:0]    bin_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 recorded,
	output logic [DATA_W-1:0]    latency,
	output logic [BIN_W-1:0]     bin_used,
	output logic [DATA_W-1:0]    record_count,
	output logic [DATA_W-1:0]    latency_sum,
	output logic [DATA_W-1:0]    bin_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data
);

	pclh_cmd_t cmd;

	// register writes only while no item is in flight
	assign cfg_ready = in_ready;

	pclh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pclh_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.func          (func),
		.context_index (context_index),
		.nested        (nested),
		.halted        (halted),
		.timestamp     (timestamp),
		.value         (value),
		.bin_index     (bin_index),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.recorded      (recorded),
		.latency       (latency),
		.bin_used      (bin_used),
		.record_count  (record_count),
		.latency_sum   (latency_sum),
		.bin_count     (bin_count)
	);

endmodule

### rtl/core/pclh_checker.sv
//------------------------------------------------------------------------------
// pclh_checker
// port-level checks on the latency histogram, bound to the top level
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module pclh_checker import pclh_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [FUNC_W-1:0]    func,
	input logic [CTX_W-1:0]     context_index,
	input logic                 nested,
	input logic                 halted,
	input logic [DATA_W-1:0]    timestamp,
	input logic [DATA_W-1:0]    value,
	input logic [BIDX_W-1:0]    bin_index,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 recorded,
	input logic [DATA_W-1:0]    latency,
	input logic [BIN_W-1:0]     bin_used,
	input logic [DATA_W-1:0]    record_count,
	input logic [DATA_W-1:0]    latency_sum,
	input logic [DATA_W-1:0]    bin_count,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic                 cfg_data
);

	`ASSERT_NEXT(a_one_item_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "input accepted while an item is in flight")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(record_count) && $stable(latency_sum) && $stable(bin_count), "result beat changed while stalled")
	`ASSERT_IMPL(a_no_record_fields, clk, arst_n, out_valid && !recorded, (latency == '0) && (bin_used == NO_BIN), "latency or bin set without a record")
	`ASSERT_IMPL(a_zero_latency_bin, clk, arst_n, out_valid && recorded && (latency == '0), bin_used == BIN_W'(1), "zero latency not counted in bin one")

endmodule

bind per_context_latency_histogram_top pclh_checker u_pclh_checker (.*);

### dv/per_context_latency_histogram_checker.sv
//------------------------------------------------------------------------------
// per_context_latency_histogram_checker
// Watches the item, result and register channels of the latency histogram.
// Keeps its own copy of the per-context stores, totals and bins, predicts
// one result per accepted item and compares every result beat field by
// field with the oldest prediction. Hands the mismatch count and the number
// of results still due to the testbench top.
//------------------------------------------------------------------------------
module per_context_latency_histogram_checker
	import pclh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [FUNC_W-1:0]    func,
	input  logic [CTX_W-1:0]     context_index,
	input  logic                 nested,
	input  logic                 halted,
	input  logic [DATA_W-1:0]    timestamp,
	input  logic [DATA_W-1:0]    value,
	input  logic [BIDX_W-1:0]    bin_index,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 recorded,
	input  logic [DATA_W-1:0]    latency,
	input  logic [BIN_W-1:0]     bin_used,
	input  logic [DATA_W-1:0]    record_count,
	input  logic [DATA_W-1:0]    latency_sum,
	input  logic [DATA_W-1:0]    bin_count,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	output int unsigned          mismatches,
	output int unsigned          results_due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              recorded;
		logic [DATA_W-1:0] latency;
		logic [BIN_W-1:0]  bin_used;
		logic [DATA_W-1:0] record_count;
		logic [DATA_W-1:0] latency_sum;
		logic [DATA_W-1:0] bin_count;
	} hist_result_t;

	logic [DATA_W-1:0] ctx_start [CONTEXTS];
	logic              ctx_event [CONTEXTS];
	logic              ctx_l1 [CONTEXTS];
	logic [DATA_W-1:0] ctx_eptp [CONTEXTS];
	logic [DATA_W-1:0] total_records;
	logic [DATA_W-1:0] running_sum;
	logic [DATA_W-1:0] bin_counts [HIST_BINS];
	logic              gate_nested;
	logic              gate_event;
	logic              gate_l1;
	hist_result_t      results_due [$];

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic int unsigned latency_bin(input logic [DATA_W-1:0] lat);
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (lat[i]) begin
				return i + 1;
			end
		end
		return 1;
	endfunction

	function automatic hist_result_t histogram_update(
		input logic [FUNC_W-1:0] f,
		input logic [CTX_W-1:0]  c,
		input logic              nst,
		input logic              hlt,
		input logic [DATA_W-1:0] ts,
		input logic [DATA_W-1:0] v,
		input logic [BIDX_W-1:0] bidx
	);
		hist_result_t r;
		logic         in_range;
		logic         gated;
		int unsigned  b;
		r = '0;
		r.bin_used = NO_BIN;
		in_range = (c < CONTEXTS);
		gated = gate_nested && !nst;
		case (f)
			F_START: begin
				if (in_range && !gated) begin
					if (gate_event) begin
						ctx_event[c] = 1'b0;
					end
					ctx_start[c] = ts;
				end
			end
			F_END: begin
				if (in_range) begin
					if (gate_l1 && gate_nested && !nst) begin
						if (ctx_start[c] != '0) begin
							ctx_l1[c] = 1'b1;
						end
					end else if (!gated && !(gate_l1 && !ctx_l1[c])
							&& !(gate_event && !ctx_event[c]) && ctx_start[c] != '0) begin
						r.recorded = 1'b1;
						r.latency = ts - ctx_start[c];
						total_records = total_records + 1'b1;
						running_sum = running_sum + r.latency;
						b = latency_bin(r.latency);
						if (b < HIST_BINS) begin
							bin_counts[b] = bin_counts[b] + 1'b1;
							r.bin_used = BIN_W'(b);
						end
						ctx_start[c] = '0;
						if (gate_l1) begin
							ctx_l1[c] = 1'b0;
						end
						if (gate_event) begin
							ctx_event[c] = 1'b0;
						end
					end
				end
			end
			F_MARK: begin
				if (in_range && !gated) begin
					ctx_event[c] = 1'b1;
				end
			end
			F_EPTP: begin
				if (in_range && ctx_eptp[c] != v) begin
					ctx_event[c] = 1'b1;
					ctx_eptp[c] = v;
				end
			end
			F_RST_ALL, F_HALT_WRD: begin
				if (f == F_RST_ALL || v[31:0] == HALT_EXIT_WORD) begin
					for (int i = 0; i < CONTEXTS; i++) begin
						ctx_start[i] = '0;
						ctx_event[i] = 1'b0;
					end
				end
			end
			F_HALT_ONE: begin
				if (in_range && hlt) begin
					ctx_start[c] = '0;
					ctx_event[c] = 1'b0;
				end
			end
			default: begin
				if (bidx < HIST_BINS) begin
					r.bin_count = bin_counts[bidx];
				end
			end
		endcase
		r.record_count = total_records;
		r.latency_sum = running_sum;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hist_result_t got;
		hist_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CONTEXTS; i++) begin
				ctx_start[i] = '0;
				ctx_event[i] = 1'b0;
				ctx_l1[i] = 1'b0;
				ctx_eptp[i] = '0;
			end
			for (int i = 0; i < HIST_BINS; i++) begin
				bin_counts[i] = '0;
			end
			total_records = '0;
			running_sum = '0;
			gate_nested = 1'b1;
			gate_event = 1'b1;
			gate_l1 = 1'b0;
			results_due.delete();
			mismatches = 0;
			results_due_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{recorded, latency, bin_used, record_count, latency_sum, bin_count};
				if (results_due.size() == 0) begin
					flag_mismatch("result beat with no item outstanding");
				end else begin
					want = results_due.pop_front();
					if (got.recorded !== want.recorded)
						flag_mismatch($sformatf("recorded got %b expected %b",
							got.recorded, want.recorded));
					if (got.latency !== want.latency)
						flag_mismatch($sformatf("latency got %h expected %h",
							got.latency, want.latency));
					if (got.bin_used !== want.bin_used)
						flag_mismatch($sformatf("bin_used got %0d expected %0d",
							got.bin_used, want.bin_used));
					if (got.record_count !== want.record_count)
						flag_mismatch($sformatf("record_count got %h expected %h",
							got.record_count, want.record_count));
					if (got.latency_sum !== want.latency_sum)
						flag_mismatch($sformatf("latency_sum got %h expected %h",
							got.latency_sum, want.latency_sum));
					if (got.bin_count !== want.bin_count)
						flag_mismatch($sformatf("bin_count got %h expected %h",
							got.bin_count, want.bin_count));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ONLY_NESTED: gate_nested = cfg_data;
					CFG_REQ_EVENT:   gate_event = cfg_data;
					CFG_REQ_L1:      gate_l1 = cfg_data;
					default:         ;
				endcase
			end
			if (in_valid && in_ready) begin
				results_due.push_back(histogram_update(func, context_index, nested, halted,
					timestamp, value, bin_index));
			end
			results_due_count = results_due.size();
		end
	end

endmodule

### dv/per_context_latency_histogram_top_tb.sv
//------------------------------------------------------------------------------
// per_context_latency_histogram_top_tb
// Drives the latency histogram with a short directed run covering the gates,
// zero and wrapping latencies, the dropped top bin and every reset item, then
// with random start/end visits and noise items under all eight register
// settings and four idling patterns. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
//------------------------------------------------------------------------------
module per_context_latency_histogram_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pclh_pkg::*;

	localparam int unsigned PHASE_BEATS = 205;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func;
	logic [CTX_W-1:0]     context_index;
	logic                 nested;
	logic                 halted;
	logic [DATA_W-1:0]    timestamp;
	logic [DATA_W-1:0]    value;
	logic [BIDX_W-1:0]    bin_index;
	logic                 out_valid;
	logic                 out_ready;
	logic                 recorded;
	logic [DATA_W-1:0]    latency;
	logic [BIN_W-1:0]     bin_used;
	logic [DATA_W-1:0]    record_count;
	logic [DATA_W-1:0]    latency_sum;
	logic [DATA_W-1:0]    bin_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic                 cfg_data;
	int unsigned          mismatches;
	int unsigned          results_due_count;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_cycles = 0;
	int unsigned beats_sent = 0;
	logic        mode_l1 = 1'b0;

	per_context_latency_histogram_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .context_index(context_index), .nested(nested), .halted(halted),
		.timestamp(timestamp), .value(value), .bin_index(bin_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.recorded(recorded), .latency(latency), .bin_used(bin_used),
		.record_count(record_count), .latency_sum(latency_sum), .bin_count(bin_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	per_context_latency_histogram_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .context_index(context_index), .nested(nested), .halted(halted),
		.timestamp(timestamp), .value(value), .bin_index(bin_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.recorded(recorded), .latency(latency), .bin_used(bin_used),
		.record_count(record_count), .latency_sum(latency_sum), .bin_count(bin_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .results_due_count(results_due_count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: random stalls, or a long counted hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_ready = 1'b0;
				for (int n = 1; n < hold_cycles; n++) begin
					@(negedge clk);
				end
				hold_cycles = 0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(
		input logic [FUNC_W-1:0] f,
		input logic [CTX_W-1:0]  c,
		input logic              nst,
		input logic              hlt,
		input logic [DATA_W-1:0] ts,
		input logic [DATA_W-1:0] v,
		input logic [BIDX_W-1:0] b
	);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid = 1'b1;
		func = f;
		context_index = c;
		nested = nst;
		halted = hlt;
		timestamp = ts;
		value = v;
		bin_index = b;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (results_due_count != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_noise();
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] v;
		f = FUNC_W'($urandom);
		if (f == F_RST_ALL && $urandom_range(3) != 0) begin
			f = F_READ;
		end
		v = rand64();
		if (f == F_HALT_WRD && $urandom_range(1) == 0) begin
			v[31:0] = HALT_EXIT_WORD;
		end
		send_beat(f, CTX_W'($urandom), 1'($urandom), 1'($urandom), rand64(), v,
			BIDX_W'($urandom));
	endtask

	// start, optional event, optional pass through L1, optional noise, end on one context, optional bin read
	task automatic run_visit();
		logic [CTX_W-1:0]  c;
		logic [DATA_W-1:0] t0;
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] lat;
		int unsigned       len;
		c = CTX_W'($urandom_range(CONTEXTS - 1));
		t0 = ($urandom_range(31) == 0) ? '0 : rand64();
		len = $urandom_range(DATA_W);
		mask = (len == DATA_W) ? '1 : ((64'd1 << len) - 64'd1);
		lat = rand64() & mask;
		send_beat(F_START, c, $urandom_range(15) != 0, 1'($urandom), t0, rand64(),
			BIDX_W'($urandom));
		if ($urandom_range(4) != 0) begin
			if ($urandom_range(1) == 0) begin
				send_beat(F_MARK, c, $urandom_range(15) != 0, 1'($urandom), rand64(),
					rand64(), BIDX_W'($urandom));
			end else begin
				send_beat(F_EPTP, c, 1'($urandom), 1'($urandom), rand64(), rand64(),
					BIDX_W'($urandom));
			end
		end
		if (mode_l1 && $urandom_range(7) != 0) begin
			send_beat(F_END, c, 1'b0, 1'($urandom), rand64(), rand64(), BIDX_W'($urandom));
		end
		if ($urandom_range(3) == 0) begin
			send_noise();
		end
		send_beat(F_END, c, $urandom_range(15) != 0, 1'($urandom), t0 + lat, rand64(),
			BIDX_W'($urandom));
		if ($urandom_range(2) == 0) begin
			send_beat(F_READ, c, 1'($urandom), 1'($urandom), rand64(), rand64(),
				BIDX_W'(len));
		end
	endtask

	initial begin : stimulus
		logic [2:0]  sel;
		int unsigned phase_end;
		bit          stall_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = F_START;
		context_index = '0;
		nested = 1'b0;
		halted = 1'b0;
		timestamp = '0;
		value = '0;
		bin_index = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ONLY_NESTED;
		cfg_data = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, register values as after reset
		send_beat(F_READ, 7'd0, 1'b0, 1'b0, '0, '0, 6'd0);
		send_beat(F_START, 7'd0, 1'b1, 1'b0, 64'd100, '0, 6'd0);
		send_beat(F_END, 7'd0, 1'b1, 1'b0, 64'd200, '0, 6'd0);
		send_beat(F_MARK, 7'd0, 1'b1, 1'b0, '0, '0, 6'd0);
		send_beat(F_END, 7'd0, 1'b1, 1'b0, 64'd300, '0, 6'd0);
		send_beat(F_START, 7'd1, 1'b0, 1'b0, 64'd50, '0, 6'd0);
		send_beat(F_EPTP, 7'd1, 1'b0, 1'b0, '0, '1, 6'd0);
		send_beat(F_EPTP, 7'd1, 1'b0, 1'b0, '0, '1, 6'd0);
		send_beat(F_START, 7'd2, 1'b1, 1'b0, '0, '0, 6'd0);
		send_beat(F_MARK, 7'd2, 1'b1, 1'b0, '0, '0, 6'd0);
		send_beat(F_END, 7'd2, 1'b1, 1'b0, 64'd500, '0, 6'd0);
		send_beat(F_START, 7'd127, 1'b1, 1'b1, 64'd1, '1, 6'd63);
		send_beat(F_MARK, 7'd127, 1'b1, 1'b1, '1, '1, 6'd63);
		send_beat(F_END, 7'd127, 1'b1, 1'b1, 64'd1, '1, 6'd63);
		send_beat(F_START, 7'd3, 1'b1, 1'b0, 64'h8000_0000_0000_0000, '0, 6'd0);
		send_beat(F_EPTP, 7'd3, 1'b1, 1'b0, '0, 64'd5, 6'd0);
		send_beat(F_END, 7'd3, 1'b1, 1'b0, 64'h7fff_ffff_ffff_ffff, '0, 6'd0);
		send_beat(F_START, 7'd4, 1'b1, 1'b0, '1, '0, 6'd0);
		send_beat(F_MARK, 7'd4, 1'b1, 1'b0, '0, '0, 6'd0);
		send_beat(F_RST_ALL, 7'd4, 1'b1, 1'b0, '0, '0, 6'd0);
		send_beat(F_END, 7'd4, 1'b1, 1'b0, '1, '0, 6'd0);
		send_beat(F_HALT_WRD, 7'd0, 1'b0, 1'b0, '0, 64'hffff_ffff_0000_0080, 6'd0);
		send_beat(F_HALT_WRD, 7'd0, 1'b0, 1'b0, '0, 64'h0000_0000_0000_0081, 6'd0);
		send_beat(F_HALT_ONE, 7'd5, 1'b0, 1'b1, '0, '0, 6'd0);
		send_beat(F_HALT_ONE, 7'd5, 1'b0, 1'b0, '0, '0, 6'd0);
		send_beat(F_READ, 7'd0, 1'b0, 1'b0, '0, '0, 6'd63);
		send_beat(F_READ, 7'd0, 1'b0, 1'b0, '0, '0, 6'd1);
		wait_all_results();

		for (int p = 0; p < 8; p++) begin
			sel = 3'(p) ^ 3'b011;
			send_idle_pct = (p % 4 == 1) ? 68 : (p % 4 == 3) ? 12 : 0;
			recv_stall_pct = (p % 4 == 2) ? 68 : (p % 4 == 3) ? 12 : 0;
			write_reg(CFG_ONLY_NESTED, sel[0]);
			write_reg(CFG_REQ_EVENT, sel[1]);
			write_reg(CFG_REQ_L1, sel[2]);
			mode_l1 = sel[2] & sel[0];
			if (p == 1) begin
				// L1 pass: with the L1 requirement off, an end from a non-nested context does not arm the flag
				send_beat(F_END, 7'd7, 1'b0, 1'b0, 64'd10, '0, 6'd0);
				send_beat(F_START, 7'd6, 1'b1, 1'b0, 64'd1000, '0, 6'd0);
				send_beat(F_MARK, 7'd6, 1'b1, 1'b0, '0, '0, 6'd0);
				send_beat(F_END, 7'd6, 1'b1, 1'b0, 64'd1100, '0, 6'd0);
				send_beat(F_END, 7'd6, 1'b0, 1'b0, 64'd1150, '0, 6'd0);
				send_beat(F_END, 7'd6, 1'b1, 1'b0, 64'd1234, '0, 6'd0);
			end
			phase_end = beats_sent + PHASE_BEATS;
			stall_done = 1'b0;
			while (beats_sent < phase_end) begin
				if (p == 2 && !stall_done && beats_sent + 150 >= phase_end) begin
					hold_cycles = 400;
					stall_done = 1'b1;
				end
				if (p == 5 && !stall_done && beats_sent + 100 >= phase_end) begin
					wait_all_results();
					stall_done = 1'b1;
				end
				if ($urandom_range(4) == 0) begin
					send_noise();
				end else begin
					run_visit();
				end
			end
			wait_all_results();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
